/* rtl/svalloc_pkg.sv */
// Shared constants, codes and structures for the synthesiser voice allocator.
// Used by every module of the allocator but svalloc_ram; depends on nothing else.
`timescale 1ns / 1ps

package svalloc_pkg;

	localparam int VOICE_COUNT = 16;
	localparam int NOTE_COUNT  = 128;
	localparam int VIDX_W      = $clog2(VOICE_COUNT);
	localparam int NOTE_W      = $clog2(NOTE_COUNT);
	localparam int VEL_W       = 7;
	localparam int PREV_W      = NOTE_W + 1;
	localparam int CMD_W       = 2;
	localparam int KIND_W      = 2;

	localparam logic [PREV_W-1:0] NO_NOTE = PREV_W'(NOTE_COUNT);

	typedef enum logic [CMD_W-1:0] {
		CMD_NOTE_ON  = 2'd0,
		CMD_NOTE_OFF = 2'd1,
		CMD_FINISH   = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		PICK_SAME      = 2'd0,
		PICK_FREE      = 2'd1,
		PICK_RELEASING = 2'd2,
		PICK_ACTIVE    = 2'd3
	} pick_kind_t;

	typedef enum logic {
		ACT_START   = 1'b0,
		ACT_RELEASE = 1'b1
	} action_t;

	typedef struct packed {
		logic              busy;
		logic              releasing;
		logic [NOTE_W-1:0] note;
		logic [VIDX_W-1:0] rank;
	} voice_rd_t;

	typedef struct packed {
		logic              start;
		logic              rel;
		logic              finish;
		logic [VIDX_W-1:0] idx;
		logic [NOTE_W-1:0] note;
		logic [VIDX_W-1:0] rank;
	} voice_op_t;

	typedef struct packed {
		logic              free_found;
		logic [VIDX_W-1:0] free_idx;
		logic              rel_found;
		logic [VIDX_W-1:0] rel_idx;
		logic [VIDX_W-1:0] old_idx;
	} scan_res_t;

endpackage

/* rtl/synth_voice_allocator.sv */
// Synthesiser voice allocator: maps note-on, note-off and voice-finished words to voice commands.
// One word at a time: the input stalls until the block is back in idle. Voice-finished and
// unknown words give no result. A polyphonic note-on first sweeps the note map when a voice
// finished or the limit was written since the last sweep, then looks up the note and scans
// the voices if it is unmapped; a result is held while the result side stalls.
// Reset is asynchronous and active low: all voices free, ranks in index order, map empty.
`timescale 1ns / 1ps

module synth_voice_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [svalloc_pkg::VIDX_W-1:0] cfg_data,
	input  logic                           event_valid,
	output logic                           event_stall,
	input  logic [svalloc_pkg::CMD_W-1:0]  command,
	input  logic [svalloc_pkg::NOTE_W-1:0] note,
	input  logic [svalloc_pkg::VEL_W-1:0]  velocity,
	input  logic [svalloc_pkg::VIDX_W-1:0] voice,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic                           action,
	output logic [svalloc_pkg::VIDX_W-1:0] voice_index,
	output logic [svalloc_pkg::NOTE_W-1:0] note_out,
	output logic [svalloc_pkg::VEL_W-1:0]  velocity_out,
	output logic [svalloc_pkg::PREV_W-1:0] previous_note,
	output logic [svalloc_pkg::KIND_W-1:0] pick_kind
);

	import svalloc_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_SWEEP  = 12'b000000000010,
		S_LOOK   = 12'b000000000100,
		S_LOOKRD = 12'b000000001000,
		S_SCAN   = 12'b000000010000,
		S_PICK   = 12'b000000100000,
		S_OLD    = 12'b000001000000,
		S_OLDRD  = 12'b000010000000,
		S_COMMIT = 12'b000100000000,
		S_OFF    = 12'b001000000000,
		S_OFFRD  = 12'b010000000000,
		S_REL    = 12'b100000000000
	} state_t;

	state_t            state_q, state_d;
	cmd_t              cmd_in;
	logic              accept;
	logic              mono;
	logic              out_free;

	logic [VIDX_W-1:0] poly_limit_q;
	logic              dirty_q;
	logic [PREV_W-1:0] last_note_q;
	logic [NOTE_COUNT-1:0] map_valid_q;
	logic [NOTE_W:0]   sw_cnt_q;
	logic [NOTE_W-1:0] sw_prev_idx;

	logic [NOTE_W-1:0] ev_note_q;
	logic [VEL_W-1:0]  ev_vel_q;
	logic [VIDX_W-1:0] target_q;
	pick_kind_t        kind_q;
	logic              old_busy_q;
	logic [NOTE_W-1:0] old_note_q;
	logic [VIDX_W-1:0] rank_q;

	logic              res_valid_q;
	action_t           res_action_q;
	logic [VIDX_W-1:0] res_voice_q;
	logic [NOTE_W-1:0] res_note_q;
	logic [VEL_W-1:0]  res_vel_q;
	logic [PREV_W-1:0] res_prev_q;
	pick_kind_t        res_kind_q;

	logic              ram_re;
	logic [NOTE_W-1:0] ram_raddr;
	logic              ram_we;
	logic [VIDX_W-1:0] ram_rdata;
	logic              mv_clr;
	logic [NOTE_W-1:0] mv_clr_idx;
	logic              mv_set;
	logic [VIDX_W-1:0] vb_idx;
	voice_op_t         vb_op;
	voice_rd_t         vb_rd;
	logic              scan_start;
	logic              scan_step;
	logic              scan_done;
	logic [VIDX_W-1:0] scan_idx;
	scan_res_t         scan_res;
	logic              emit_start;
	logic              emit_rel;

	assign cmd_in      = cmd_t'(command);
	assign event_stall = (state_q != S_IDLE);
	assign accept      = event_valid && (state_q == S_IDLE);
	assign mono        = (poly_limit_q == '0);
	assign out_free    = !res_valid_q || !result_stall;
	assign sw_prev_idx = sw_cnt_q[NOTE_W-1:0] - 1'b1;

	svalloc_ram #(
		.WIDTH (VIDX_W),
		.DEPTH (NOTE_COUNT)
	) u_note_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ev_note_q),
		.wdata (target_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	svalloc_voice_bank u_voice_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (vb_idx),
		.op     (vb_op),
		.rd     (vb_rd)
	);

	svalloc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.step   (scan_step),
		.lim    (poly_limit_q),
		.vrd    (vb_rd),
		.idx    (scan_idx),
		.done   (scan_done),
		.res    (scan_res)
	);

	always_comb begin
		state_d     = state_q;
		ram_re      = 1'b0;
		ram_raddr   = ev_note_q;
		ram_we      = 1'b0;
		mv_clr      = 1'b0;
		mv_clr_idx  = ev_note_q;
		mv_set      = 1'b0;
		vb_idx      = target_q;
		vb_op       = '0;
		vb_op.idx   = target_q;
		vb_op.note  = ev_note_q;
		vb_op.rank  = rank_q;
		scan_start  = 1'b0;
		scan_step   = 1'b0;
		emit_start  = 1'b0;
		emit_rel    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd_in)
						CMD_NOTE_ON: begin
							if (mono) begin
								state_d = S_OLD;
							end else if (dirty_q) begin
								state_d = S_SWEEP;
							end else begin
								state_d = S_LOOK;
							end
						end
						CMD_NOTE_OFF: begin
							if (mono) begin
								mv_clr     = 1'b1;
								mv_clr_idx = note;
								if (last_note_q == {1'b0, note}) begin
									state_d = S_REL;
								end
							end else begin
								state_d = S_OFF;
							end
						end
						CMD_FINISH: begin
							vb_op.finish = 1'b1;
							vb_op.idx    = voice;
						end
						CMD_NONE: begin
						end
					endcase
				end
			end
			S_SWEEP: begin
				// The entry read in the previous cycle is dropped when its voice is out of
				// range or no longer sounding.
				vb_idx = ram_rdata;
				if ((sw_cnt_q != '0) && ((ram_rdata > poly_limit_q) || !vb_rd.busy)) begin
					mv_clr     = 1'b1;
					mv_clr_idx = sw_prev_idx;
				end
				if (sw_cnt_q[NOTE_W]) begin
					state_d = S_LOOK;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = sw_cnt_q[NOTE_W-1:0];
				end
			end
			S_LOOK: begin
				ram_re  = 1'b1;
				state_d = S_LOOKRD;
			end
			S_LOOKRD: begin
				if (map_valid_q[ev_note_q]) begin
					state_d = S_OLD;
				end else begin
					scan_start = 1'b1;
					state_d    = S_SCAN;
				end
			end
			S_SCAN: begin
				vb_idx    = scan_idx;
				scan_step = 1'b1;
				if (scan_done) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				state_d = S_OLD;
			end
			S_OLD: begin
				ram_re    = 1'b1;
				ram_raddr = vb_rd.note;
				state_d   = S_OLDRD;
			end
			S_OLDRD: begin
				// A stolen voice's previous note no longer points at it.
				if (old_busy_q && (old_note_q != ev_note_q) && map_valid_q[old_note_q]
						&& (ram_rdata == target_q)) begin
					mv_clr     = 1'b1;
					mv_clr_idx = old_note_q;
				end
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (out_free) begin
					ram_we      = 1'b1;
					mv_set      = 1'b1;
					vb_op.start = 1'b1;
					emit_start  = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_OFF: begin
				ram_re  = 1'b1;
				state_d = S_OFFRD;
			end
			S_OFFRD: begin
				if (map_valid_q[ev_note_q]) begin
					mv_clr  = 1'b1;
					state_d = S_REL;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_REL: begin
				if (out_free) begin
					vb_op.rel = 1'b1;
					emit_rel  = 1'b1;
					state_d   = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			poly_limit_q <= '0;
			dirty_q      <= 1'b0;
			last_note_q  <= NO_NOTE;
			map_valid_q  <= '0;
			sw_cnt_q     <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				poly_limit_q <= cfg_data;
			end
			if (cfg_write || (accept && (cmd_in == CMD_FINISH))) begin
				dirty_q <= 1'b1;
			end else if ((state_q == S_SWEEP) && sw_cnt_q[NOTE_W]) begin
				dirty_q <= 1'b0;
			end
			if (state_q == S_IDLE) begin
				sw_cnt_q <= '0;
			end else if ((state_q == S_SWEEP) && !sw_cnt_q[NOTE_W]) begin
				sw_cnt_q <= sw_cnt_q + 1'b1;
			end
			if (mv_clr) begin
				map_valid_q[mv_clr_idx] <= 1'b0;
			end
			if (mv_set) begin
				map_valid_q[ev_note_q] <= 1'b1;
			end
			if (emit_start) begin
				last_note_q <= {1'b0, ev_note_q};
			end
			if (emit_start || emit_rel) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_note_q <= note;
			ev_vel_q  <= velocity;
			target_q  <= '0;
		end
		if ((state_q == S_LOOKRD) || (state_q == S_OFFRD)) begin
			target_q <= ram_rdata;
			kind_q   <= PICK_SAME;
		end
		if (state_q == S_PICK) begin
			if (scan_res.free_found) begin
				target_q <= scan_res.free_idx;
				kind_q   <= PICK_FREE;
			end else if (scan_res.rel_found) begin
				target_q <= scan_res.rel_idx;
				kind_q   <= PICK_RELEASING;
			end else begin
				target_q <= scan_res.old_idx;
				kind_q   <= PICK_ACTIVE;
			end
		end
		if (state_q == S_OLD) begin
			old_busy_q <= vb_rd.busy;
			old_note_q <= vb_rd.note;
			rank_q     <= vb_rd.rank;
			if (mono) begin
				if (!vb_rd.busy) begin
					kind_q <= PICK_FREE;
				end else if (vb_rd.releasing) begin
					kind_q <= PICK_RELEASING;
				end else if (vb_rd.note == ev_note_q) begin
					kind_q <= PICK_SAME;
				end else begin
					kind_q <= PICK_ACTIVE;
				end
			end
		end
		if (emit_start) begin
			res_action_q <= ACT_START;
			res_voice_q  <= target_q;
			res_note_q   <= ev_note_q;
			res_vel_q    <= ev_vel_q;
			res_prev_q   <= last_note_q;
			res_kind_q   <= kind_q;
		end else if (emit_rel) begin
			res_action_q <= ACT_RELEASE;
			res_voice_q  <= target_q;
			res_note_q   <= ev_note_q;
			res_vel_q    <= '0;
			res_prev_q   <= NO_NOTE;
			res_kind_q   <= PICK_SAME;
		end
	end

	assign result_valid  = res_valid_q;
	assign action        = res_action_q;
	assign voice_index   = res_voice_q;
	assign note_out      = res_note_q;
	assign velocity_out  = res_vel_q;
	assign previous_note = res_prev_q;
	assign pick_kind     = res_kind_q;

endmodule

/* rtl/svalloc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the note-to-voice map of the allocator.
`timescale 1ns / 1ps

module svalloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/svalloc_voice_bank.sv */
// Per-voice state of the allocator: busy and releasing marks, held note and age rank.
// One shared read port; start, release and finish operations. Depends on svalloc_pkg.
`timescale 1ns / 1ps

module svalloc_voice_bank (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [svalloc_pkg::VIDX_W-1:0] rd_idx,
	input  svalloc_pkg::voice_op_t         op,
	output svalloc_pkg::voice_rd_t         rd
);

	import svalloc_pkg::*;

	logic [VOICE_COUNT-1:0] busy_q;
	logic [VOICE_COUNT-1:0] rel_q;
	logic [NOTE_W-1:0]      note_q [VOICE_COUNT];
	logic [VIDX_W-1:0]      rank_q [VOICE_COUNT];

	assign rd.busy      = busy_q[rd_idx];
	assign rd.releasing = rel_q[rd_idx];
	assign rd.note      = note_q[rd_idx];
	assign rd.rank      = rank_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			rel_q  <= '0;
			for (int i = 0; i < VOICE_COUNT; i++) begin
				rank_q[i] <= VIDX_W'(i);
			end
		end else begin
			if (op.start) begin
				busy_q[op.idx] <= 1'b1;
				rel_q[op.idx]  <= 1'b0;
				// Every voice younger than the started one moves one place towards the oldest.
				for (int i = 0; i < VOICE_COUNT; i++) begin
					if (rank_q[i] > op.rank) begin
						rank_q[i] <= rank_q[i] - 1'b1;
					end
				end
				rank_q[op.idx] <= VIDX_W'(VOICE_COUNT - 1);
			end
			if (op.rel && busy_q[op.idx]) begin
				rel_q[op.idx] <= 1'b1;
			end
			if (op.finish) begin
				busy_q[op.idx] <= 1'b0;
				rel_q[op.idx]  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.start) begin
			note_q[op.idx] <= op.note;
		end
	end

endmodule

/* rtl/svalloc_scan.sv */
// Voice search unit: steps through voices one per cycle while step is high, tracking
// the first free voice, the oldest releasing voice and the oldest voice. Depends on svalloc_pkg.
`timescale 1ns / 1ps

module svalloc_scan (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           step,
	input  logic [svalloc_pkg::VIDX_W-1:0] lim,
	input  svalloc_pkg::voice_rd_t         vrd,
	output logic [svalloc_pkg::VIDX_W-1:0] idx,
	output logic                           done,
	output svalloc_pkg::scan_res_t         res
);

	import svalloc_pkg::*;

	logic [VIDX_W-1:0] idx_q;
	logic [VIDX_W-1:0] rel_rank_q;
	logic [VIDX_W-1:0] old_rank_q;
	scan_res_t         res_q;
	logic              rel_better;
	logic              old_better;

	assign rel_better = vrd.releasing && (!res_q.rel_found || (vrd.rank < rel_rank_q));
	assign old_better = (idx_q == '0) || (vrd.rank < old_rank_q);
	// A free voice ends the search, since it beats every other choice.
	assign done       = step && ((idx_q == lim) || !vrd.busy);
	assign idx        = idx_q;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			res_q <= '0;
		end else if (start) begin
			idx_q            <= '0;
			res_q.free_found <= 1'b0;
			res_q.rel_found  <= 1'b0;
		end else if (step) begin
			if (!vrd.busy && !res_q.free_found) begin
				res_q.free_found <= 1'b1;
				res_q.free_idx   <= idx_q;
			end
			if (rel_better) begin
				res_q.rel_found <= 1'b1;
				res_q.rel_idx   <= idx_q;
			end
			if (old_better) begin
				res_q.old_idx <= idx_q;
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (step && rel_better) begin
			rel_rank_q <= vrd.rank;
		end
		if (step && old_better) begin
			old_rank_q <= vrd.rank;
		end
	end

endmodule

/* verif/synth_voice_allocator_tb.sv */
`timescale 1ns / 1ps
// Testbench for synth_voice_allocator: a directed table of note words, then random phases
// under several voice limits, each result checked against the row's expected command or a
// voice allocation predictor. Depends on svalloc_pkg and the synth_voice_allocator RTL.

module synth_voice_allocator_tb;
	import svalloc_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 200;
	localparam int PHASE_WORDS   = 100;
	localparam int LONG_HOLD     = 400;

	typedef logic [NOTE_W-1:0] note_t;
	typedef logic [VIDX_W-1:0] vidx_t;
	typedef logic [VEL_W-1:0]  vel_t;
	typedef logic [PREV_W-1:0] prev_t;

	typedef struct packed {
		action_t    act;
		vidx_t      vidx;
		note_t      nt;
		vel_t       vel;
		prev_t      prev;
		pick_kind_t kind;
	} voice_cmd_t;

	typedef struct {
		bit         is_cfg;
		vidx_t      cfg_val;
		cmd_t       cmd;
		note_t      nt;
		vel_t       vel;
		vidx_t      vc;
		bit         typed;
		bit         has_cmd;
		voice_cmd_t cmd_out;
	} stim_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_write;
	vidx_t                   cfg_data;
	logic                    event_valid;
	logic                    event_stall;
	logic [CMD_W-1:0]        command;
	note_t                   note;
	vel_t                    velocity;
	vidx_t                   voice;
	logic                    result_valid;
	logic                    result_stall;
	logic                    action;
	vidx_t                   voice_index;
	note_t                   note_out;
	vel_t                    velocity_out;
	prev_t                   previous_note;
	logic [KIND_W-1:0]       pick_kind;

	bit                      note_bound    [NOTE_COUNT];
	vidx_t                   note_slot     [NOTE_COUNT];
	bit                      slot_has_note [VOICE_COUNT];
	note_t                   slot_note     [VOICE_COUNT];
	bit                      slot_busy     [VOICE_COUNT];
	bit                      slot_fading   [VOICE_COUNT];
	vidx_t                   slot_age      [VOICE_COUNT];
	prev_t                   glide_from;
	vidx_t                   slot_limit;

	voice_cmd_t              cmds_due[$];
	int unsigned             fail_cnt;
	bit                      src_idle;
	bit                      sink_idle;
	int unsigned             hold_req;

	synth_voice_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.event_valid   (event_valid),
		.event_stall   (event_stall),
		.command       (command),
		.note          (note),
		.velocity      (velocity),
		.voice         (voice),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.action        (action),
		.voice_index   (voice_index),
		.note_out      (note_out),
		.velocity_out  (velocity_out),
		.previous_note (previous_note),
		.pick_kind     (pick_kind)
	);

	initial begin : clock_gen
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic voice_cmd_t cmd_of(action_t a, vidx_t vi, note_t n, vel_t vel, prev_t p,
			pick_kind_t k);
		voice_cmd_t c;
		c.act  = a;
		c.vidx = vi;
		c.nt   = n;
		c.vel  = vel;
		c.prev = p;
		c.kind = k;
		return c;
	endfunction

	function automatic stim_row_t ev(cmd_t c, note_t n, vel_t vel, vidx_t v);
		stim_row_t r;
		r.is_cfg  = 1'b0;
		r.cfg_val = '0;
		r.cmd     = c;
		r.nt      = n;
		r.vel     = vel;
		r.vc      = v;
		r.typed   = 1'b0;
		r.has_cmd = 1'b0;
		r.cmd_out = '0;
		return r;
	endfunction

	function automatic stim_row_t ev_typed(stim_row_t r, bit has_cmd, voice_cmd_t c);
		r.typed   = 1'b1;
		r.has_cmd = has_cmd;
		r.cmd_out = c;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(vidx_t val);
		stim_row_t r;
		r = ev(CMD_NONE, '0, '0, '0);
		r.is_cfg  = 1'b1;
		r.cfg_val = val;
		return r;
	endfunction

	// Starting a voice drops the old note's mapping if it still points here, then makes
	// the voice the newest in the age ranking.
	function automatic voice_cmd_t start_slot(vidx_t v, note_t n, vel_t vel, pick_kind_t kind);
		voice_cmd_t c;
		vidx_t      r;
		if (slot_has_note[v] && slot_note[v] != n && note_bound[slot_note[v]] &&
				note_slot[slot_note[v]] == v)
			note_bound[slot_note[v]] = 1'b0;
		note_bound[n]    = 1'b1;
		note_slot[n]     = v;
		slot_has_note[v] = 1'b1;
		slot_note[v]     = n;
		slot_busy[v]     = 1'b1;
		slot_fading[v]   = 1'b0;
		r = slot_age[v];
		for (int i = 0; i < VOICE_COUNT; i++)
			if (slot_age[i] > r)
				slot_age[i] = slot_age[i] - 1'b1;
		slot_age[v] = vidx_t'(VOICE_COUNT - 1);
		c = cmd_of(ACT_START, v, n, vel, glide_from, kind);
		glide_from = {1'b0, n};
		return c;
	endfunction

	function automatic bit next_voice_cmd(input cmd_t c, input note_t n, input vel_t vel,
			input vidx_t v, output voice_cmd_t res);
		pick_kind_t kind;
		vidx_t      pick;
		bit         found;
		bit         gives;
		int         best_age;
		res   = '0;
		kind  = PICK_SAME;
		pick  = '0;
		found = 1'b0;
		gives = 1'b0;
		best_age = VOICE_COUNT;
		case (c)
		CMD_NOTE_ON: begin
			if (slot_limit == 0) begin
				if (!slot_busy[0])
					kind = PICK_FREE;
				else if (slot_fading[0])
					kind = PICK_RELEASING;
				else if (slot_has_note[0] && slot_note[0] == n)
					kind = PICK_SAME;
				else
					kind = PICK_ACTIVE;
			end else begin
				for (int i = 0; i < NOTE_COUNT; i++)
					if (note_bound[i] && (note_slot[i] > slot_limit || !slot_busy[note_slot[i]]))
						note_bound[i] = 1'b0;
				if (note_bound[n]) begin
					pick  = note_slot[n];
					kind  = PICK_SAME;
					found = 1'b1;
				end
				for (int i = 0; i <= slot_limit && !found; i++)
					if (!slot_busy[i]) begin
						pick  = vidx_t'(i);
						kind  = PICK_FREE;
						found = 1'b1;
					end
				if (!found)
					for (int i = 0; i <= slot_limit; i++)
						if (slot_fading[i] && int'(slot_age[i]) < best_age) begin
							best_age = slot_age[i];
							pick     = vidx_t'(i);
							kind     = PICK_RELEASING;
							found    = 1'b1;
						end
				if (!found)
					for (int i = 0; i <= slot_limit; i++)
						if (int'(slot_age[i]) < best_age) begin
							best_age = slot_age[i];
							pick     = vidx_t'(i);
							kind     = PICK_ACTIVE;
						end
			end
			res   = start_slot(pick, n, vel, kind);
			gives = 1'b1;
		end
		CMD_NOTE_OFF: begin
			if (slot_limit == 0) begin
				note_bound[n] = 1'b0;
				gives = (glide_from == {1'b0, n});
			end else if (note_bound[n]) begin
				pick = note_slot[n];
				note_bound[n] = 1'b0;
				gives = 1'b1;
			end
			if (gives) begin
				if (slot_busy[pick])
					slot_fading[pick] = 1'b1;
				res = cmd_of(ACT_RELEASE, pick, n, '0, NO_NOTE, PICK_SAME);
			end
		end
		CMD_FINISH: begin
			slot_busy[v]     = 1'b0;
			slot_fading[v]   = 1'b0;
			slot_has_note[v] = 1'b0;
		end
		default: ;
		endcase
		return gives;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_cnt++;
		end
	endfunction

	// The predictor is stepped at the edge where the word is accepted, so it sees words
	// in the order that the block does.
	task automatic offer(input cmd_t c, input note_t n, input vel_t vel, input vidx_t v,
			input bit typed, input bit has_cmd, input voice_cmd_t typed_cmd);
		int unsigned gap;
		voice_cmd_t  pred;
		bit          gives;
		gap = src_idle ? $urandom_range(0, 10) : 0;
		if (gap != 0) begin
			@(negedge clk);
			event_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		event_valid = 1'b1;
		command     = c;
		note        = n;
		velocity    = vel;
		voice       = v;
		do @(posedge clk); while (event_stall);
		gives = next_voice_cmd(c, n, vel, v, pred);
		if (typed) begin
			if (has_cmd)
				cmds_due.push_back(typed_cmd);
		end else if (gives) begin
			cmds_due.push_back(pred);
		end
	endtask

	task automatic write_limit(input vidx_t val);
		@(negedge clk);
		event_valid = 1'b0;
		while (cmds_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_write = 1'b1;
		cfg_data  = val;
		@(negedge clk);
		cfg_write  = 1'b0;
		slot_limit = val;
	endtask

	initial begin : result_sink
		int unsigned hold;
		voice_cmd_t  due;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req != 0) begin
				hold     = hold_req;
				hold_req = 0;
			end else begin
				hold = sink_idle ? $urandom_range(0, 10) : 0;
			end
			@(negedge clk);
			if (hold != 0) begin
				result_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall = 1'b0;
			do @(posedge clk); while (!result_valid);
			if (cmds_due.size() == 0) begin
				$error("result word with none due: voice_index %0d, note_out %0d",
					voice_index, note_out);
				fail_cnt++;
			end else begin
				due = cmds_due.pop_front();
				check_field("action", 8'(due.act), 8'(action));
				check_field("voice_index", 8'(due.vidx), 8'(voice_index));
				check_field("note_out", 8'(due.nt), 8'(note_out));
				check_field("velocity_out", 8'(due.vel), 8'(velocity_out));
				check_field("previous_note", due.prev, previous_note);
				check_field("pick_kind", 8'(due.kind), 8'(pick_kind));
			end
		end
	end

	initial begin : watchdog
		int unsigned cycle_cnt;
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[synth_voice_allocator] ERROR");
		$finish;
	end

	initial begin : stimulus
		stim_row_t   rows[$];
		vidx_t       phase_limit [8];
		note_t       held_q[$];
		note_t       n;
		vel_t        vel;
		vidx_t       v;
		int unsigned roll;
		int unsigned idx;
		int unsigned k;
		arst_n      = 1'b0;
		cfg_write   = 1'b0;
		cfg_data    = '0;
		event_valid = 1'b0;
		command     = CMD_NONE;
		note        = '0;
		velocity    = '0;
		voice       = '0;
		fail_cnt    = 0;
		src_idle    = 1'b1;
		sink_idle   = 1'b1;
		hold_req    = 0;
		for (int i = 0; i < NOTE_COUNT; i++) begin
			note_bound[i] = 1'b0;
			note_slot[i]  = '0;
		end
		for (int i = 0; i < VOICE_COUNT; i++) begin
			slot_has_note[i] = 1'b0;
			slot_note[i]     = '0;
			slot_busy[i]     = 1'b0;
			slot_fading[i]   = 1'b0;
			slot_age[i]      = vidx_t'(i);
		end
		glide_from = NO_NOTE;
		slot_limit = '0;

		rows.push_back(cfg_row(4'd0));
		rows.push_back(ev_typed(ev(CMD_NOTE_ON, 7'd0, 7'd127, 4'd0), 1'b1,
			cmd_of(ACT_START, 4'd0, 7'd0, 7'd127, NO_NOTE, PICK_FREE)));
		rows.push_back(ev_typed(ev(CMD_NOTE_ON, 7'd127, 7'd0, 4'd15), 1'b1,
			cmd_of(ACT_START, 4'd0, 7'd127, 7'd0, 8'd0, PICK_ACTIVE)));
		rows.push_back(ev_typed(ev(CMD_NOTE_ON, 7'd127, 7'd64, 4'd0), 1'b1,
			cmd_of(ACT_START, 4'd0, 7'd127, 7'd64, 8'd127, PICK_SAME)));
		rows.push_back(ev_typed(ev(CMD_NOTE_OFF, 7'd5, 7'd0, 4'd0), 1'b0, '0));
		rows.push_back(ev_typed(ev(CMD_NOTE_OFF, 7'd127, 7'd127, 4'd0), 1'b1,
			cmd_of(ACT_RELEASE, 4'd0, 7'd127, 7'd0, NO_NOTE, PICK_SAME)));
		rows.push_back(ev_typed(ev(CMD_NOTE_ON, 7'd60, 7'd100, 4'd0), 1'b1,
			cmd_of(ACT_START, 4'd0, 7'd60, 7'd100, 8'd127, PICK_RELEASING)));
		rows.push_back(ev_typed(ev(CMD_FINISH, 7'd0, 7'd0, 4'd0), 1'b0, '0));
		rows.push_back(ev(CMD_NOTE_ON, 7'd61, 7'd1, 4'd0));
		rows.push_back(ev_typed(ev(CMD_NONE, 7'd127, 7'd127, 4'd15), 1'b0, '0));
		rows.push_back(ev_typed(ev(CMD_FINISH, 7'd127, 7'd127, 4'd15), 1'b0, '0));
		rows.push_back(cfg_row(4'd15));
		rows.push_back(ev(CMD_NOTE_ON, 7'd61, 7'd33, 4'd0));
		rows.push_back(ev(CMD_NOTE_ON, 7'd62, 7'd90, 4'd0));
		rows.push_back(ev(CMD_NOTE_ON, 7'd63, 7'd45, 4'd15));
		rows.push_back(ev(CMD_NOTE_ON, 7'd64, 7'd127, 4'd0));
		rows.push_back(ev(CMD_NOTE_OFF, 7'd62, 7'd0, 4'd0));
		rows.push_back(ev_typed(ev(CMD_NOTE_OFF, 7'd100, 7'd0, 4'd0), 1'b0, '0));
		rows.push_back(cfg_row(4'd1));
		rows.push_back(ev(CMD_NOTE_ON, 7'd70, 7'd20, 4'd0));
		rows.push_back(ev(CMD_NOTE_ON, 7'd71, 7'd120, 4'd0));
		rows.push_back(ev(CMD_NOTE_OFF, 7'd61, 7'd0, 4'd0));
		rows.push_back(ev(CMD_FINISH, 7'd0, 7'd0, 4'd1));
		rows.push_back(ev(CMD_NOTE_OFF, 7'd70, 7'd0, 4'd0));
		rows.push_back(ev(CMD_NOTE_ON, 7'd73, 7'd64, 4'd0));

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			if (rows[i].is_cfg)
				write_limit(rows[i].cfg_val);
			else
				offer(rows[i].cmd, rows[i].nt, rows[i].vel, rows[i].vc, rows[i].typed,
					rows[i].has_cmd, rows[i].cmd_out);
		end

		phase_limit = '{4'd15, 4'd0, 4'd3, 4'd1, 4'd15, 4'd5, 4'd7, 4'd2};
		phase_limit[5] = vidx_t'($urandom_range(2, 14));
		for (int p = 0; p < 8; p++) begin
			write_limit(phase_limit[p]);
			// Phase two runs flat out; phase four also holds the result side off for a
			// long stretch so that the block backs up and stalls its input.
			src_idle  = (p != 2 && p != 4);
			sink_idle = (p != 2 && p != 4);
			if (p == 4)
				hold_req = LONG_HOLD;
			k = 0;
			while (k < PHASE_WORDS) begin
				roll = $urandom_range(0, 99);
				vel  = vel_t'($urandom_range(0, 127));
				v    = vidx_t'($urandom_range(0, 15));
				if (roll < 45) begin
					if ($urandom_range(0, 1))
						n = note_t'($urandom_range(0, 127));
					else
						n = note_t'(48 + $urandom_range(0, 15));
					offer(CMD_NOTE_ON, n, vel, v, 1'b0, 1'b0, '0);
					held_q.push_back(n);
					k++;
				end else if (roll < 75) begin
					if (held_q.size() != 0 && $urandom_range(0, 9) < 8) begin
						idx = $urandom_range(0, held_q.size() - 1);
						n   = held_q[idx];
						held_q.delete(idx);
					end else begin
						n = note_t'($urandom_range(0, 127));
					end
					offer(CMD_NOTE_OFF, n, vel, v, 1'b0, 1'b0, '0);
					k++;
				end else if (roll < 95) begin
					if ($urandom_range(0, 3) != 0)
						v = vidx_t'($urandom_range(0, slot_limit));
					offer(CMD_FINISH, note_t'($urandom_range(0, 127)), vel, v, 1'b0, 1'b0, '0);
					k++;
				end else begin
					offer(CMD_NONE, note_t'($urandom_range(0, 127)), vel, v, 1'b0, 1'b0, '0);
				end
			end
		end

		@(negedge clk);
		event_valid = 1'b0;
		while (cmds_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_cnt == 0)
			$display("[synth_voice_allocator] OK");
		else
			$display("[synth_voice_allocator] ERROR");
		$finish;
	end

endmodule
